// File: rtl/core/rotor_byte_cipher_defines.svh
// assertion macros shared by the rotor byte cipher rtl
`ifndef ROTOR_BYTE_CIPHER_DEFINES_SVH
`define ROTOR_BYTE_CIPHER_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication, checked out of reset
`define RBC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rotor_byte_cipher: same-cycle check failed");

// next-cycle implication, checked out of reset
`define RBC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rotor_byte_cipher: next-cycle check failed");

`else

`define RBC_ASSERT_NOW(label, clk, rst, ante, cons)
`define RBC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: rtl/core/rbc_pkg.sv
// types and constants of the rotor byte cipher
package rbc_pkg;

   localparam int RotorSize = 256;
   localparam int IdxW      = $clog2(RotorSize);

   typedef logic [IdxW-1:0] idx_type;
   typedef logic [7:0]      byte_type;

   // function codes carried in tuser
   typedef enum logic [1:0] {
      FUNC_CIPHER = 2'd0,
      FUNC_LOAD   = 2'd1,
      FUNC_RESET  = 2'd2
   } func_type;

   // payload carried down the lookup pipeline
   typedef struct packed {
      logic     cipher;
      byte_type data;
      idx_type  idx;
      byte_type perm;
      byte_type refl;
      idx_type  fpos;
      idx_type  spos;
   } stage_type;

endpackage

// File: rtl/core/rotor_byte_cipher.sv
// rotor byte cipher: single rotor with reflector, one byte per cycle unless rsp stalls
//
// Input channel req_*: one item per handshake. req_tuser selects the
// function (cipher a byte, load one entry of each table, reset rotor positions);
// req_tdata carries the byte and the load fields. Result channel rsp_*:
// one ciphered byte for each cipher item, in order; loads and position
// resets give no result.
// A cipher item accepted on req passes through s0_ff, s1_ff, s2_ff, s3_ff
// and the output register to rsp. Throughput is one item per cycle
// for any mix of functions when the receiver is ready: each of the four tables
// is a 256 x 8 memory with one port, written by loads and read by ciphers in
// its own pipeline stage, so the four dependent lookups overlap across items.
// Positions step when a cipher item is accepted, so no pipeline hazard arises.
// Reset clears the rotor positions and the pipeline valid bits; the
// tables stay unwritten until loaded, and must be loaded before use.
// When the receiver stalls, results stay in the output register and the
// pipeline keeps filling behind it; req_tready falls only once every
// stage holds an item.
`include "rotor_byte_cipher_defines.svh"

module rotor_byte_cipher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // data_byte, load_index, perm_value, reflect_value
   input  logic [1:0]  req_tuser,   // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // out_byte
);
   import rbc_pkg::*;

   // table memories
   byte_type offset_mem [RotorSize];
   byte_type perm_mem   [RotorSize];
   byte_type refl_mem   [RotorSize];
   byte_type inv_mem    [RotorSize];

   // positions
   idx_type   fast_ff, fast_in;
   idx_type   slow_ff, slow_in;

   // pipeline stages
   logic      s0_valid_ff, s1_valid_ff, s2_valid_ff, s3_valid_ff, out_valid_ff;
   stage_type s0_ff, s1_ff, s2_ff, s3_ff, s0_in;
   byte_type  o1_ff, o2_ff, o3_ff, o4_ff;
   byte_type  a2_ff, b3_ff, c4_ff;

   logic      req_accept, enq;
   logic      out_ready, rdy0, rdy1, rdy2, rdy3;
   logic      mv0, mv1, mv2, mv3;

   // handshake and stage ready chain
   assign out_ready  = !out_valid_ff || rsp_tready;
   assign rdy3       = !s3_valid_ff || !s3_ff.cipher || out_ready;
   assign rdy2       = !s2_valid_ff || rdy3;
   assign rdy1       = !s1_valid_ff || rdy2;
   assign rdy0       = !s0_valid_ff || rdy1;
   assign mv0        = s0_valid_ff && rdy1;
   assign mv1        = s1_valid_ff && rdy2;
   assign mv2        = s2_valid_ff && rdy3;
   assign mv3        = s3_valid_ff && rdy3;
   assign req_tready = rdy0;
   assign req_accept = req_tvalid && req_tready;
   assign enq        = req_accept && (req_tuser == FUNC_CIPHER || req_tuser == FUNC_LOAD);

   // incoming item with the positions it uses
   always_comb begin
      s0_in.cipher = (req_tuser == FUNC_CIPHER);
      s0_in.data   = req_tdata[7:0];
      s0_in.idx    = req_tdata[15:8];
      s0_in.perm   = req_tdata[23:16];
      s0_in.refl   = req_tdata[31:24];
      s0_in.fpos   = fast_ff;
      s0_in.spos   = slow_ff;
   end

   // odometer stepping
   always_comb begin
      fast_in = fast_ff;
      slow_in = slow_ff;
      if (req_accept) begin
         case (req_tuser)
            FUNC_CIPHER: begin
               fast_in = fast_ff + idx_type'(1);
               if (fast_ff == idx_type'(RotorSize - 1)) begin
                  slow_in = slow_ff + idx_type'(1);
               end
            end
            FUNC_RESET: begin
               fast_in = '0;
               slow_in = '0;
            end
            default: begin
               fast_in = fast_ff;
               slow_in = slow_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fast_ff <= '0;
         slow_ff <= '0;
      end else begin
         fast_ff <= fast_in;
         slow_ff <= slow_in;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (rdy0) s0_valid_ff <= enq;
         if (rdy1) s1_valid_ff <= s0_valid_ff;
         if (rdy2) s2_valid_ff <= s1_valid_ff;
         if (rdy3) s3_valid_ff <= s2_valid_ff;
         if (out_ready) out_valid_ff <= s3_valid_ff && s3_ff.cipher;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (rdy0) s0_ff <= s0_in;
      if (mv0)  s1_ff <= s0_ff;
      if (mv1) begin
         s2_ff <= s1_ff;
         o2_ff <= o1_ff;
      end
      if (mv2) begin
         s3_ff <= s2_ff;
         o3_ff <= o2_ff;
      end
      if (mv3 && s3_ff.cipher) o4_ff <= o3_ff;
   end

   // stage 0: offset table, indexed by the fast position
   always_ff @(posedge clock) begin
      if (mv0) begin
         if (!s0_ff.cipher) offset_mem[s0_ff.idx] <= s0_ff.perm + s0_ff.refl;
         else o1_ff <= offset_mem[s0_ff.fpos];
      end
   end

   // stage 1: rotor permutation at byte plus offset
   always_ff @(posedge clock) begin
      if (mv1) begin
         if (!s1_ff.cipher) perm_mem[s1_ff.idx] <= s1_ff.perm;
         else a2_ff <= perm_mem[s1_ff.data + o1_ff];
      end
   end

   // stage 2: reflector at rotor output plus slow position
   always_ff @(posedge clock) begin
      if (mv2) begin
         if (!s2_ff.cipher) refl_mem[s2_ff.idx] <= s2_ff.refl;
         else b3_ff <= refl_mem[a2_ff + s2_ff.spos];
      end
   end

   // stage 3: inverse rotor at reflector output minus slow position
   always_ff @(posedge clock) begin
      if (mv3) begin
         if (!s3_ff.cipher) inv_mem[s3_ff.perm] <= s3_ff.idx;
         if (s3_ff.cipher) c4_ff <= inv_mem[b3_ff - s3_ff.spos];
      end
   end

   // result item
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = c4_ff - o4_ff;

   // checks
   `RBC_ASSERT_NEXT(a_fast_step, clock, reset, req_accept && req_tuser == FUNC_CIPHER,
      fast_ff == $past(fast_ff) + idx_type'(1))
   `RBC_ASSERT_NEXT(a_slow_wrap, clock, reset,
      req_accept && req_tuser == FUNC_CIPHER && fast_ff != idx_type'(RotorSize - 1),
      slow_ff == $past(slow_ff))
   `RBC_ASSERT_NEXT(a_pos_clear, clock, reset, req_accept && req_tuser == FUNC_RESET,
      fast_ff == '0 && slow_ff == '0)
   `RBC_ASSERT_NOW(a_stall_full, clock, reset, !req_tready,
      s0_valid_ff && s1_valid_ff && s2_valid_ff && s3_valid_ff && out_valid_ff)

endmodule
